// ===== rtl/core/wtc_pkg.sv =====
// Shared types and constants for the whitespace trim and collapse core.
`default_nettype none

package wtc_pkg;

  // Width of the release count carried by a command; covers the largest
  // supported pending store depth of 63.
  localparam int unsigned CNT_W = 6;

  // Command queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Enough to count every release command in the queue plus the one in work.
  localparam int unsigned REL_W = 3;

  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0]       data;
    logic             has_byte;
    logic             eos;
    logic             ovf;
    logic [CNT_W-1:0] cnt;
  } wtc_cmd_t;

  typedef struct packed {
    logic rel_done;
  } wtc_back_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/wtc_if.sv =====
// Valid/ready channel interfaces for the input and output byte streams.
`default_nettype none

interface wtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface wtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_string;
  logic       overflow;

  modport source (output valid, output out_byte, output has_byte,
                  output end_of_string, output overflow, input ready);
  modport sink   (input valid, input out_byte, input has_byte,
                  input end_of_string, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wtc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module wtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/wtc_front.sv =====
// Front end: accepts input beats, classifies them and tracks string state.
`default_nettype none

module wtc_front #(
  parameter int unsigned PENDING_DEPTH = 16,
  localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  wtc_in_if.sink                      in_i,
  input  wire logic                   full_i,
  input  wire wtc_pkg::wtc_back_sts_t sts_i,
  output logic                        push_o,
  output wtc_pkg::wtc_cmd_t           cmd_o,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [7:0]                  ram_wdata_o
);

  logic                        quoted_q, quoted_d;
  logic                        started_q, started_d;
  logic                        lks_q, lks_d;
  logic                        dropped_q, dropped_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [wtc_pkg::REL_W-1:0]   rel_q, rel_d;

  logic is_ws, is_quote, keep_ws, has_room, wr_ws, drop_ws, needs_cmd, accept;

  assign is_ws = (in_i.in_byte == wtc_pkg::CHAR_SPACE) ||
                 ((in_i.in_byte >= wtc_pkg::CHAR_TAB) && (in_i.in_byte <= wtc_pkg::CHAR_CR));
  assign is_quote = (in_i.in_byte == wtc_pkg::CHAR_SQUOTE) ||
                    (in_i.in_byte == wtc_pkg::CHAR_DQUOTE);
  assign keep_ws  = is_ws && started_q && (quoted_q || !lks_q);
  assign has_room = cnt_q < CW'(PENDING_DEPTH);
  assign wr_ws    = keep_ws && has_room;
  assign drop_ws  = keep_ws && !has_room;
  assign needs_cmd = !is_ws || in_i.in_last;

  // A pending write waits until the back end has read out every earlier
  // release, since both start from entry zero of the store.
  assign in_i.ready = !full_i && (!wr_ws || (rel_q == '0));
  assign accept     = in_i.valid && in_i.ready;

  assign ram_we_o    = accept && wr_ws;
  assign ram_waddr_o = cnt_q[AW-1:0];
  assign ram_wdata_o = in_i.in_byte;

  assign push_o = accept && needs_cmd;

  always_comb begin
    cmd_o.data     = is_ws ? 8'h00 : in_i.in_byte;
    cmd_o.has_byte = !is_ws;
    cmd_o.eos      = in_i.in_last;
    cmd_o.ovf      = dropped_q || drop_ws;
    cmd_o.cnt      = is_ws ? '0 : wtc_pkg::CNT_W'(cnt_q);
  end

  always_comb begin
    quoted_d  = quoted_q;
    started_d = started_q;
    lks_d     = lks_q;
    dropped_d = dropped_q;
    cnt_d     = cnt_q;
    if (accept) begin
      if (is_ws) begin
        if (keep_ws) begin
          lks_d = 1'b1;
          if (has_room) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
        end
      end else begin
        if (is_quote) begin
          quoted_d = !quoted_q;
        end
        cnt_d     = '0;
        started_d = 1'b1;
        lks_d     = 1'b0;
      end
      if (in_i.in_last) begin
        quoted_d  = 1'b0;
        started_d = 1'b0;
        lks_d     = 1'b0;
        dropped_d = 1'b0;
        cnt_d     = '0;
      end
    end
  end

  always_comb begin
    rel_d = rel_q;
    if (push_o && (cmd_o.cnt != '0)) begin
      rel_d = rel_d + 1'b1;
    end
    if (sts_i.rel_done) begin
      rel_d = rel_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      started_q <= 1'b0;
      lks_q     <= 1'b0;
      dropped_q <= 1'b0;
      cnt_q     <= '0;
      rel_q     <= '0;
    end else begin
      quoted_q  <= quoted_d;
      started_q <= started_d;
      lks_q     <= lks_d;
      dropped_q <= dropped_d;
      cnt_q     <= cnt_d;
      rel_q     <= rel_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wtc_cmd_fifo.sv =====
// Short command queue between the front and the back end.
`default_nettype none

module wtc_cmd_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire wtc_pkg::wtc_cmd_t  cmd_i,
  input  wire logic               pop_i,
  output wtc_pkg::wtc_cmd_t       cmd_o,
  output logic                    empty_o,
  output logic                    full_o
);

  wtc_pkg::wtc_cmd_t            slot_q [wtc_pkg::QUEUE_DEPTH];
  logic [wtc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [wtc_pkg::QCNT_W-1:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == wtc_pkg::QCNT_W'(wtc_pkg::QUEUE_DEPTH));
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wtc_back.sv =====
// Back end: releases pending whitespace from the store and emits output beats.
`default_nettype none

module wtc_back #(
  parameter int unsigned PENDING_DEPTH = 16,
  localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wtc_pkg::wtc_cmd_t  cmd_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output wtc_pkg::wtc_back_sts_t  sts_o,
  output logic                    ram_re_o,
  output logic [AW-1:0]           ram_raddr_o,
  input  wire logic [7:0]         ram_rdata_i,
  wtc_out_if.source               out_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [wtc_pkg::CNT_W-1:0]   idx_q, idx_d, idx_nxt;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       has_q, has_d, eos_q, eos_d, ovf_q, ovf_d;
  logic       out_free, load;

  assign out_free = !out_valid_q || out_o.ready;
  assign idx_nxt  = idx_q + 1'b1;

  assign ram_raddr_o = idx_q[AW-1:0];

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    load       = 1'b0;
    out_byte_d = out_byte_q;
    has_d      = has_q;
    eos_d      = eos_q;
    ovf_d      = ovf_q;
    pop_o      = 1'b0;
    ram_re_o   = 1'b0;
    sts_o.rel_done = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          idx_d   = '0;
          state_d = (cmd_i.cnt != '0) ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        // Read data stays put until the next read, so a stalled output is fine.
        if (out_free) begin
          load       = 1'b1;
          out_byte_d = ram_rdata_i;
          has_d      = 1'b1;
          eos_d      = 1'b0;
          ovf_d      = cmd_i.ovf;
          idx_d      = idx_nxt;
          state_d    = (idx_nxt < cmd_i.cnt) ? S_READ : S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          out_byte_d = cmd_i.data;
          has_d      = cmd_i.has_byte;
          eos_d      = cmd_i.eos;
          ovf_d      = cmd_i.ovf;
          pop_o      = 1'b1;
          sts_o.rel_done = (cmd_i.cnt != '0);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    has_q      <= has_d;
    eos_q      <= eos_d;
    ovf_q      <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.has_byte      = has_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.overflow      = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/whitespace_trim_collapse_core.sv =====
// Top level of the whitespace trim and collapse core.
`default_nettype none

// Strings arrive one byte per beat with a last flag. Leading and trailing
// whitespace is removed, whitespace runs outside quotes shrink to their first
// byte, and whitespace inside quotes is kept up to PENDING_DEPTH bytes per run,
// with the overflow flag set for the rest of the string once bytes are lost.
// A byte that produces no result or a single result is taken as soon as the
// command queue has room; the front end queues up to four commands ahead of
// the back end. A byte that releases n pending whitespace bytes keeps the back
// end busy while each pending byte is read from the store and then loaded into
// the output register, before the byte itself is emitted. While such a release
// is still queued or running, a whitespace byte that must enter the store is
// held off. There is no clearing pass after reset.
module whitespace_trim_collapse_core #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wtc_in_if.sink     in_i,
  wtc_out_if.source  out_o
);

  localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  wtc_pkg::wtc_cmd_t      push_cmd, head_cmd;
  wtc_pkg::wtc_back_sts_t back_sts;
  logic                   push, pop, q_empty, q_full;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [7:0]             ram_wdata, ram_rdata;

  wtc_front #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (q_full),
    .sts_i       (back_sts),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  wtc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  wtc_ram #(
    .WIDTH(8),
    .DEPTH(PENDING_DEPTH)
  ) u_pending_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wtc_back #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .sts_o       (back_sts),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

  // The store is never written while a release is reading it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("pending store written during a release read");

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // A beat without a character is always the bare end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && !out_o.has_byte) |->
                   (out_o.end_of_string && (out_o.out_byte == 8'h00)))
    else $error("bare beat without end of string");

endmodule

`default_nettype wire

// ===== sim/whitespace_trim_collapse_core_tb.sv =====
// Self-checking testbench for the whitespace trim and collapse core.
`timescale 1ns / 1ps

module whitespace_trim_collapse_core_tb;

  localparam int unsigned PENDING_DEPTH = 16;
  localparam int unsigned RANDOM_BEATS  = 140;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_byte;
    logic       eos;
    logic       ovf;
  } out_beat_t;

  typedef logic [7:0] text_t[$];

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wtc_in_if  in_ch ();
  wtc_out_if out_ch ();

  whitespace_trim_collapse_core #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #10 clk_i = ~clk_i;

  in_beat_t    text_q[$];
  out_beat_t   expected_q[$];
  logic        in_taken = 1'b0;
  int unsigned total_beats = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned strings_done = 0;
  int unsigned bare_ends = 0;
  int unsigned ovf_beats = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Predictor state, mirroring what the core keeps per string.
  logic        in_quote = 1'b0;
  logic        text_begun = 1'b0;
  logic        space_last = 1'b0;
  logic [7:0]  held_ws[PENDING_DEPTH];
  int unsigned held_cnt = 0;
  logic        ws_lost = 1'b0;

  function automatic logic is_blank(logic [7:0] c);
    return c == wtc_pkg::CHAR_SPACE ||
           (c >= wtc_pkg::CHAR_TAB && c <= wtc_pkg::CHAR_CR);
  endfunction

  task automatic trim_collapse_step(input logic [7:0] c, input logic last);
    if (is_blank(c)) begin
      if (text_begun && (in_quote || !space_last)) begin
        if (held_cnt < PENDING_DEPTH) begin
          held_ws[held_cnt] = c;
          held_cnt++;
        end else begin
          ws_lost = 1'b1;
        end
        space_last = 1'b1;
      end
      if (last) begin
        expected_q.push_back(out_beat_t'{8'h00, 1'b0, 1'b1, ws_lost});
      end
    end else begin
      if (c == wtc_pkg::CHAR_SQUOTE || c == wtc_pkg::CHAR_DQUOTE) begin
        in_quote = !in_quote;
      end
      if (text_begun) begin
        for (int i = 0; i < held_cnt; i++) begin
          expected_q.push_back(out_beat_t'{held_ws[i], 1'b1, 1'b0, ws_lost});
        end
      end
      held_cnt   = 0;
      text_begun = 1'b1;
      space_last = 1'b0;
      expected_q.push_back(out_beat_t'{c, 1'b1, last, ws_lost});
    end
    if (last) begin
      in_quote   = 1'b0;
      text_begun = 1'b0;
      space_last = 1'b0;
      held_cnt   = 0;
      ws_lost    = 1'b0;
    end
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? wtc_pkg::CHAR_SPACE : wtc_pkg::CHAR_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] random_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return blank_char();
    end else if (r < 50) begin
      return $urandom_range(0, 1) ? wtc_pkg::CHAR_SQUOTE : wtc_pkg::CHAR_DQUOTE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_text(input text_t s);
    foreach (s[i]) begin
      text_q.push_back(in_beat_t'{s[i], i == s.size() - 1});
    end
  endtask

  task automatic push_random_string();
    text_t       s;
    int unsigned len;
    len = $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0: begin
        repeat (len) s.push_back(blank_char());
      end
      1, 2: begin
        // Long whitespace run after an opening quote, so the store can fill up.
        s.push_back($urandom_range(0, 1) ? wtc_pkg::CHAR_SQUOTE : wtc_pkg::CHAR_DQUOTE);
        repeat ($urandom_range(0, 3)) s.push_back(random_char());
        repeat ($urandom_range(12, 20)) s.push_back(blank_char());
        repeat (len) s.push_back(random_char());
      end
      default: begin
        repeat (len) s.push_back(random_char());
      end
    endcase
    push_text(s);
  endtask

  // Input side: a new beat is offered once the previous one has been taken.
  always @(negedge clk_i) begin
    int unsigned gap_pct;
    int unsigned stall_pct;
    in_beat_t    nxt;
    if (beats_in < total_beats / 3) begin
      gap_pct   = 14;
      stall_pct = 47;
    end else if (beats_in < 2 * total_beats / 3) begin
      gap_pct   = 47;
      stall_pct = 14;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    if (rst_ni) begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!in_ch.valid || in_taken) begin
        if (text_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = text_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= nxt.ch;
          in_ch.in_last <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Both channels are sampled at the rising edge.
  always @(posedge clk_i) begin
    out_beat_t exp_b;
    in_taken <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      trim_collapse_step(in_ch.in_byte, in_ch.in_last);
      beats_in++;
      if (in_ch.in_last) begin
        strings_done++;
      end
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (out_ch.overflow) begin
        ovf_beats++;
      end
      if (!out_ch.has_byte) begin
        bare_ends++;
      end
      if (expected_q.size() == 0) begin
        errors++;
        $error("output beat with nothing expected: out_byte %h has_byte %b eos %b",
               out_ch.out_byte, out_ch.has_byte, out_ch.end_of_string);
      end else begin
        exp_b = expected_q.pop_front();
        if (out_ch.out_byte !== exp_b.ch) begin
          errors++;
          $error("out_byte: expected %h, got %h", exp_b.ch, out_ch.out_byte);
        end
        if (out_ch.has_byte !== exp_b.has_byte) begin
          errors++;
          $error("has_byte: expected %b, got %b", exp_b.has_byte, out_ch.has_byte);
        end
        if (out_ch.end_of_string !== exp_b.eos) begin
          errors++;
          $error("end_of_string: expected %b, got %b", exp_b.eos, out_ch.end_of_string);
        end
        if (out_ch.overflow !== exp_b.ovf) begin
          errors++;
          $error("overflow: expected %b, got %b", exp_b.ovf, out_ch.overflow);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[whitespace_trim_collapse_core] ERROR");
      $finish;
    end
  end

  initial begin
    text_t       s;
    int unsigned directed_n;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;

    // Whitespace-only string: a lone bare end marker.
    s = '{wtc_pkg::CHAR_SPACE};
    push_text(s);
    // Leading blank, NUL and 0xFF as ordinary bytes, a collapsed run, a double quote
    // closed by a single quote with whitespace kept inside, and a trailing blank end.
    s = '{wtc_pkg::CHAR_SPACE, 8'h00, wtc_pkg::CHAR_TAB, 8'h0B, wtc_pkg::CHAR_DQUOTE,
          wtc_pkg::CHAR_SPACE, wtc_pkg::CHAR_SQUOTE, 8'h0C, 8'h0C, 8'hFF,
          wtc_pkg::CHAR_SPACE, wtc_pkg::CHAR_CR};
    push_text(s);
    // Seventeen blanks inside quotes overflow the store; a final byte releases it.
    s.delete();
    s.push_back(wtc_pkg::CHAR_DQUOTE);
    for (int k = 0; k < 17; k++) begin
      s.push_back((k % 6 == 5) ? wtc_pkg::CHAR_SPACE : wtc_pkg::CHAR_TAB + 8'(k % 6));
    end
    s.push_back(8'h41);
    push_text(s);

    directed_n = text_q.size();
    while (text_q.size() < directed_n + RANDOM_BEATS) begin
      push_random_string();
    end
    total_beats = text_q.size();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_ch.valid) @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d strings in %0d input beats; checked %0d output beats,",
             strings_done, beats_in, beats_out);
    $display("  of them %0d bare end markers and %0d with the overflow flag set.",
             bare_ends, ovf_beats);
    if (errors == 0) begin
      $display("[whitespace_trim_collapse_core] OK");
    end else begin
      $display("[whitespace_trim_collapse_core] ERROR");
    end
    $finish;
  end

endmodule
